### rtl/core/cube_uv_pkg.sv
// ----------------------------------------------------------------------------
// cube_uv_pkg
// Shared constants for the cube-map face and (u, v) projection pipeline.
// ----------------------------------------------------------------------------
package cube_uv_pkg;

  // Default widths: component in two's complement, coordinate in Q0.F.
  localparam int COMPONENT_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int FACE_BITS = 3;

  // Face codes.
  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

endpackage

### rtl/core/cube_direction_to_face_uv.sv
// ----------------------------------------------------------------------------
// cube_direction_to_face_uv
// Cube-map face selection and (u, v) projection of a signed direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one direction beat: dir_x,
//   dir_y, dir_z, two's complement, COMPONENT_BITS wide, any scale.
//   Result channel (out_valid / out_stall) carries one beat per input beat:
//   face code (0=+X 1=-X 2=+Y 3=-Y 4=+Z 5=-Z), coord_u and coord_v in
//   unsigned Q0.FRACTION_BITS (1.0 saturates to all ones) and zero_vector,
//   set with face 0 and zero coordinates when all components are zero.
//   A beat is taken at a rising edge with valid high and stall low.
//   Throughput: one beat per clock while out_stall is low. A beat passes
//   through stage A, stage B, the fraction stages and the output register; the depth is set
//   by the divider: one restoring quotient bit per stage, two lanes (u, v).
//   Stall: while a result waits with out_stall high, the whole pipeline
//   holds and in_stall is raised; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all stage valid bits; the pipe is
//   empty afterwards and ready in the next cycle.
// ----------------------------------------------------------------------------
module cube_direction_to_face_uv
  import cube_uv_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // direction beats
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_BITS-1:0] in_dir_x,
  input  logic signed [COMPONENT_BITS-1:0] in_dir_y,
  input  logic signed [COMPONENT_BITS-1:0] in_dir_z,
  // result beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [FACE_BITS-1:0]             out_face_id,
  output logic [FRACTION_BITS-1:0]         out_coord_u,
  output logic [FRACTION_BITS-1:0]         out_coord_v,
  output logic                             out_zero_vector
);

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;

  // Global advance: the pipe moves unless a result is held by the receiver.
  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage A: magnitudes, major axis, face and signed numerators.
  // --------------------------------------------------------------------------
  logic signed [CB:0] ext_x, ext_y, ext_z;
  logic signed [CB:0] abs_x, abs_y, abs_z;
  logic [CB-1:0]      ax, ay, az;
  logic               sel_z, sel_x, is_zero;

  logic               a_valid_r;
  logic [FACE_BITS-1:0] a_face_r, a_face_nxt;
  logic               a_zero_r;
  logic [CB-1:0]      a_m_r, a_m_nxt;
  logic signed [CB:0] a_nu_r, a_nu_nxt;
  logic signed [CB:0] a_nv_r, a_nv_nxt;

  always_comb begin
    ext_x = {in_dir_x[CB-1], in_dir_x};
    ext_y = {in_dir_y[CB-1], in_dir_y};
    ext_z = {in_dir_z[CB-1], in_dir_z};
    abs_x = ext_x[CB] ? -ext_x : ext_x;
    abs_y = ext_y[CB] ? -ext_y : ext_y;
    abs_z = ext_z[CB] ? -ext_z : ext_z;
    // most negative value still fits: magnitude is at most 2^(CB-1)
    ax = abs_x[CB-1:0];
    ay = abs_y[CB-1:0];
    az = abs_z[CB-1:0];
    is_zero = (ax == '0) && (ay == '0) && (az == '0);
    // Z wins all ties with it; an x/y tie goes to X
    sel_z = (az >= ax) && (az >= ay);
    sel_x = (ax >= ay);

    if (sel_z) begin
      a_m_nxt  = az;
      a_nv_nxt = -ext_y;
      if (!ext_z[CB] && (az != '0)) begin
        a_face_nxt = FACE_POS_Z;
        a_nu_nxt   = ext_x;
      end else begin
        a_face_nxt = FACE_NEG_Z;
        a_nu_nxt   = -ext_x;
      end
    end else if (sel_x) begin
      a_m_nxt  = ax;
      a_nv_nxt = -ext_y;
      if (!ext_x[CB]) begin
        a_face_nxt = FACE_POS_X;
        a_nu_nxt   = -ext_z;
      end else begin
        a_face_nxt = FACE_NEG_X;
        a_nu_nxt   = ext_z;
      end
    end else begin
      a_m_nxt  = ay;
      a_nu_nxt = ext_x;
      if (!ext_y[CB]) begin
        a_face_nxt = FACE_POS_Y;
        a_nv_nxt   = ext_z;
      end else begin
        a_face_nxt = FACE_NEG_Y;
        a_nv_nxt   = -ext_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_face_r <= a_face_nxt;
      a_zero_r <= is_zero;
      a_m_r    <= a_m_nxt;
      a_nu_r   <= a_nu_nxt;
      a_nv_r   <= a_nv_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: offset numerator (n + m, range 0..2m), integer quotient bit.
  // t = floor((n + m) * 2^F / m) is built one bit a stage; the rounded
  // coordinate is then (t + 1) >> 1.
  // --------------------------------------------------------------------------
  logic signed [CB+1:0] sum_u, sum_v;
  logic [CB:0]          num_u, num_v, m_ext, m_dbl;
  logic [CB:0]          dif_u, dif_v;
  logic                 ib_u, ib_v;

  logic               b_valid_r;
  logic [FACE_BITS-1:0] b_face_r;
  logic               b_zero_r;
  logic [CB-1:0]      b_m_r;
  logic [CB-1:0]      b_ru_r, b_rv_r;
  logic               b_qu_r, b_qv_r;
  logic               b_fullu_r, b_fullv_r;

  always_comb begin
    m_ext = {1'b0, a_m_r};
    m_dbl = {a_m_r, 1'b0};
    sum_u = {a_nu_r[CB], a_nu_r} + {2'b00, a_m_r};
    sum_v = {a_nv_r[CB], a_nv_r} + {2'b00, a_m_r};
    num_u = sum_u[CB:0];
    num_v = sum_v[CB:0];
    ib_u  = (num_u >= m_ext);
    ib_v  = (num_v >= m_ext);
    dif_u = ib_u ? (num_u - m_ext) : num_u;
    dif_v = ib_v ? (num_v - m_ext) : num_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_face_r  <= a_face_r;
      b_zero_r  <= a_zero_r;
      b_m_r     <= a_m_r;
      b_ru_r    <= dif_u[CB-1:0];
      b_rv_r    <= dif_v[CB-1:0];
      b_qu_r    <= ib_u;
      b_qv_r    <= ib_v;
      // coordinate exactly 1.0: saturate later
      b_fullu_r <= (num_u == m_dbl);
      b_fullv_r <= (num_v == m_dbl);
    end
  end

  // --------------------------------------------------------------------------
  // Fraction stages: one restoring quotient bit per stage on each lane.
  // --------------------------------------------------------------------------
  logic                 f_valid_r [FB];
  logic [FACE_BITS-1:0] f_face_r  [FB];
  logic                 f_zero_r  [FB];
  logic [CB-1:0]        f_m_r     [FB];
  logic [CB-1:0]        f_ru_r    [FB];
  logic [CB-1:0]        f_rv_r    [FB];
  logic [FB:0]          f_qu_r    [FB];
  logic [FB:0]          f_qv_r    [FB];
  logic                 f_fullu_r [FB];
  logic                 f_fullv_r [FB];

  for (genvar k = 0; k < FB; k++) begin : g_div
    logic                 p_valid;
    logic [FACE_BITS-1:0] p_face;
    logic                 p_zero;
    logic [CB-1:0]        p_m, p_ru, p_rv;
    logic [FB:0]          p_qu, p_qv;
    logic                 p_fullu, p_fullv;
    logic [CB:0]          r2_u, r2_v, dm;
    logic [CB:0]          rn_u, rn_v;
    logic                 ge_u, ge_v;

    if (k == 0) begin : g_first
      assign p_valid = b_valid_r;
      assign p_face  = b_face_r;
      assign p_zero  = b_zero_r;
      assign p_m     = b_m_r;
      assign p_ru    = b_ru_r;
      assign p_rv    = b_rv_r;
      assign p_qu    = {{FB{1'b0}}, b_qu_r};
      assign p_qv    = {{FB{1'b0}}, b_qv_r};
      assign p_fullu = b_fullu_r;
      assign p_fullv = b_fullv_r;
    end else begin : g_next
      assign p_valid = f_valid_r[k-1];
      assign p_face  = f_face_r[k-1];
      assign p_zero  = f_zero_r[k-1];
      assign p_m     = f_m_r[k-1];
      assign p_ru    = f_ru_r[k-1];
      assign p_rv    = f_rv_r[k-1];
      assign p_qu    = f_qu_r[k-1];
      assign p_qv    = f_qv_r[k-1];
      assign p_fullu = f_fullu_r[k-1];
      assign p_fullv = f_fullv_r[k-1];
    end

    always_comb begin
      dm   = {1'b0, p_m};
      r2_u = {p_ru, 1'b0};
      r2_v = {p_rv, 1'b0};
      ge_u = (r2_u >= dm);
      ge_v = (r2_v >= dm);
      rn_u = ge_u ? (r2_u - dm) : r2_u;
      rn_v = ge_v ? (r2_v - dm) : r2_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        f_valid_r[k] <= 1'b0;
      end else if (adv) begin
        f_valid_r[k] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        f_face_r[k]  <= p_face;
        f_zero_r[k]  <= p_zero;
        f_m_r[k]     <= p_m;
        f_ru_r[k]    <= rn_u[CB-1:0];
        f_rv_r[k]    <= rn_v[CB-1:0];
        f_qu_r[k]    <= {p_qu[FB-1:0], ge_u};
        f_qv_r[k]    <= {p_qv[FB-1:0], ge_v};
        f_fullu_r[k] <= p_fullu;
        f_fullv_r[k] <= p_fullv;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round half up, saturate at one, zero-vector override.
  // --------------------------------------------------------------------------
  logic [FB+1:0]        rnd_u, rnd_v;
  logic [FB:0]          qr_u, qr_v;
  logic [FB-1:0]        cu_nxt, cv_nxt;
  logic [FACE_BITS-1:0] face_nxt;

  logic [FACE_BITS-1:0] out_face_r;
  logic [FB-1:0]        out_u_r, out_v_r;
  logic                 out_zero_r;

  always_comb begin
    rnd_u = {1'b0, f_qu_r[FB-1]} + {{(FB+1){1'b0}}, 1'b1};
    rnd_v = {1'b0, f_qv_r[FB-1]} + {{(FB+1){1'b0}}, 1'b1};
    qr_u  = rnd_u[FB+1:1];
    qr_v  = rnd_v[FB+1:1];
    cu_nxt = (f_fullu_r[FB-1] || qr_u[FB]) ? {FB{1'b1}} : qr_u[FB-1:0];
    cv_nxt = (f_fullv_r[FB-1] || qr_v[FB]) ? {FB{1'b1}} : qr_v[FB-1:0];
    face_nxt = f_face_r[FB-1];
    if (f_zero_r[FB-1]) begin
      cu_nxt   = '0;
      cv_nxt   = '0;
      face_nxt = FACE_POS_X;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_valid_r[FB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_face_r <= face_nxt;
      out_u_r    <= cu_nxt;
      out_v_r    <= cv_nxt;
      out_zero_r <= f_zero_r[FB-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_face_id     = out_face_r;
  assign out_coord_u     = out_u_r;
  assign out_coord_v     = out_v_r;
  assign out_zero_vector = out_zero_r;

endmodule
